>>> rtl/core/cosine_similarity_stream_defines.svh
// assertion macros for the cosine similarity stream block
// used by files that assert; expects clk and arst_n in scope
`ifndef COSINE_SIMILARITY_STREAM_DEFINES_SVH
`define COSINE_SIMILARITY_STREAM_DEFINES_SVH

// same-cycle implication
`define CSIM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/csim_pkg.sv
// shared types and constants for the cosine similarity stream block
// no dependencies
package csim_pkg;

	localparam int IN_W = 16;
	localparam int SIM_W = 16;
	localparam int ACC_W = 48;
	localparam int FRAC_W = 15;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam int SQ_ROOT_W = ACC_W / 2;
	localparam int SQ_REM_W = SQ_ROOT_W + 2;
	localparam int SQRT_STEPS = SQ_ROOT_W;

	localparam int QUOT_W = SIM_W + 1;
	localparam int DIV_STEPS = QUOT_W;
	localparam int NUM_W = ACC_W + FRAC_W;
	localparam int DSR_W = ACC_W + QUOT_W - 1;
	localparam int CNT_W = $clog2(SQRT_STEPS);

	localparam logic [QUOT_W-1:0] POS_LIM = QUOT_W'(2 ** (SIM_W - 1) - 1);
	localparam logic [QUOT_W-1:0] NEG_LIM = QUOT_W'(2 ** (SIM_W - 1));
	localparam logic [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W - 1){1'b1}}};
	localparam logic [SIM_W-1:0] SIM_MIN = {1'b1, {(SIM_W - 1){1'b0}}};

	typedef struct packed {
		logic signed [ACC_W-1:0] dot;
		logic [ACC_W-1:0] sum_xx;
		logic [ACC_W-1:0] sum_yy;
	} sums_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQRT,
		BK_MUL,
		BK_CHECK,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage

>>> rtl/core/csim_if.sv
// item channel interfaces: element pairs in, similarity results out
// depends on csim_pkg
interface csim_in_if import csim_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [IN_W-1:0] x_elem;
	logic signed [IN_W-1:0] y_elem;
	logic last;

	modport source(output valid, output x_elem, output y_elem, output last, input ready);
	modport sink(input valid, input x_elem, input y_elem, input last, output ready);
endinterface

interface csim_out_if import csim_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [SIM_W-1:0] similarity;
	logic zero_norm;
	logic saturated;

	modport source(output valid, output similarity, output zero_norm, output saturated,
		input ready);
	modport sink(input valid, input similarity, input zero_norm, input saturated,
		output ready);
endinterface

>>> rtl/core/csim_front.sv
// front end: registered products and saturating running sums
// depends on csim_pkg and csim_in_if; pushes finished sums to the queue
module csim_front import csim_pkg::*; #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	csim_in_if.sink        elems,
	output logic           push,
	output sums_t          push_data,
	input  logic           q_full
);

	localparam int PW = 2 * ELEM_WIDTH;
	localparam logic signed [ACC_W-1:0] CROSS_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] CROSS_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

	logic signed [ELEM_WIDTH-1:0] xe, ye;
	logic signed [PW-1:0] xy_s1;
	logic [PW-1:0] xx_s1, yy_s1;
	logic last_s1, valid_s1;
	logic advance;

	logic signed [ACC_W-1:0] acc_cross_q;
	logic [ACC_W-1:0] acc_xx_q, acc_yy_q;
	logic signed [ACC_W:0] cross_sum;
	logic [ACC_W:0] xx_sum, yy_sum;
	sums_t next_sums;

	assign xe = elems.x_elem[ELEM_WIDTH-1:0];
	assign ye = elems.y_elem[ELEM_WIDTH-1:0];

	assign advance = !(valid_s1 && last_s1 && q_full);
	assign elems.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= elems.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && elems.valid) begin
			xy_s1 <= xe * ye;
			xx_s1 <= xe * xe;
			yy_s1 <= ye * ye;
			last_s1 <= elems.last;
		end
	end

	always_comb begin
		cross_sum = (ACC_W + 1)'(acc_cross_q) + (ACC_W + 1)'(xy_s1);
		xx_sum = {1'b0, acc_xx_q} + (ACC_W + 1)'(xx_s1);
		yy_sum = {1'b0, acc_yy_q} + (ACC_W + 1)'(yy_s1);

		if (cross_sum[ACC_W] != cross_sum[ACC_W-1]) begin
			next_sums.dot = cross_sum[ACC_W] ? CROSS_MIN : CROSS_MAX;
		end else begin
			next_sums.dot = cross_sum[ACC_W-1:0];
		end
		next_sums.sum_xx = xx_sum[ACC_W] ? {ACC_W{1'b1}} : xx_sum[ACC_W-1:0];
		next_sums.sum_yy = yy_sum[ACC_W] ? {ACC_W{1'b1}} : yy_sum[ACC_W-1:0];
	end

	assign push = valid_s1 && last_s1 && !q_full;
	assign push_data = next_sums;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cross_q <= '0;
			acc_xx_q <= '0;
			acc_yy_q <= '0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				acc_cross_q <= '0;
				acc_xx_q <= '0;
				acc_yy_q <= '0;
			end else begin
				acc_cross_q <= next_sums.dot;
				acc_xx_q <= next_sums.sum_xx;
				acc_yy_q <= next_sums.sum_yy;
			end
		end
	end

endmodule

>>> rtl/core/csim_queue.sv
// short queue of finished sums between front and back
// depends on csim_pkg
module csim_queue import csim_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  sums_t push_data,
	input  logic  pop,
	output sums_t pop_data,
	output logic  empty,
	output logic  full
);

	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	sums_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/csim_back.sv
// back end: two bit-serial square roots, one multiply, a restoring divide
// depends on csim_pkg and csim_out_if; takes sums from the queue
module csim_back import csim_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  sums_t      pop_data,
	input  logic       q_empty,
	output logic       pop,
	csim_out_if.source result
);

	back_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] vx_q, vy_q;
	logic [SQ_REM_W-1:0] remx_q, remy_q;
	logic [SQ_ROOT_W-1:0] rootx_q, rooty_q;
	logic [SQ_REM_W+SQ_ROOT_W-1:0] stepx, stepy;
	logic neg_q, zero_q;
	logic [ACC_W-1:0] mag_q, den_q;
	logic [NUM_W-1:0] drem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [QUOT_W-1:0] quot_q;
	logic ovf, load_out;
	logic signed [SIM_W-1:0] sim_val;
	logic sat_val;
	logic out_valid_q, out_zero_q, out_sat_q;
	logic signed [SIM_W-1:0] out_sim_q;

	function automatic logic [SQ_REM_W+SQ_ROOT_W-1:0] sqrt_step(
		input logic [SQ_REM_W-1:0] rem,
		input logic [1:0] pair,
		input logic [SQ_ROOT_W-1:0] root
	);
		logic [SQ_REM_W+1:0] sh, trial;
		sh = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (sh >= trial) begin
			return {SQ_REM_W'(sh - trial), root[SQ_ROOT_W-2:0], 1'b1};
		end
		return {SQ_REM_W'(sh), root[SQ_ROOT_W-2:0], 1'b0};
	endfunction

	assign stepx = sqrt_step(remx_q, vx_q[ACC_W-1:ACC_W-2], rootx_q);
	assign stepy = sqrt_step(remy_q, vy_q[ACC_W-1:ACC_W-2], rooty_q);
	assign ovf = {2'b00, mag_q, {FRAC_W{1'b0}}} >= {den_q, {QUOT_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					state_d = BK_SQRT;
				end
			end
			BK_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_CHECK;
			end
			BK_CHECK: begin
				state_d = (den_q == '0 || ovf) ? BK_FIN : BK_DIV;
			end
			BK_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				vx_q <= pop_data.sum_xx;
				vy_q <= pop_data.sum_yy;
				neg_q <= pop_data.dot[ACC_W-1];
				mag_q <= pop_data.dot[ACC_W-1] ? ~pop_data.dot + 1'b1 : pop_data.dot;
				remx_q <= '0;
				remy_q <= '0;
				rootx_q <= '0;
				rooty_q <= '0;
				cnt_q <= '0;
			end
			BK_SQRT: begin
				{remx_q, rootx_q} <= stepx;
				{remy_q, rooty_q} <= stepy;
				vx_q <= {vx_q[ACC_W-3:0], 2'b00};
				vy_q <= {vy_q[ACC_W-3:0], 2'b00};
				cnt_q <= cnt_q + 1'b1;
			end
			BK_MUL: begin
				den_q <= rootx_q * rooty_q;
			end
			BK_CHECK: begin
				cnt_q <= '0;
				zero_q <= (den_q == '0);
				drem_q <= {mag_q, {FRAC_W{1'b0}}};
				dsr_q <= {den_q, {(QUOT_W - 1){1'b0}}};
				quot_q <= (den_q != '0 && ovf) ? {QUOT_W{1'b1}} : '0;
			end
			BK_DIV: begin
				if ({1'b0, drem_q} >= dsr_q) begin
					drem_q <= drem_q - dsr_q[NUM_W-1:0];
					quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
				end else begin
					quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
				end
				dsr_q <= dsr_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sim_val = '0;
		sat_val = 1'b0;
		if (!zero_q) begin
			if (!neg_q) begin
				if (quot_q > POS_LIM) begin
					sim_val = SIM_MAX;
					sat_val = 1'b1;
				end else begin
					sim_val = quot_q[SIM_W-1:0];
				end
			end else begin
				if (quot_q > NEG_LIM) begin
					sim_val = SIM_MIN;
					sat_val = 1'b1;
				end else begin
					sim_val = SIM_W'(~quot_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sim_q <= sim_val;
			out_zero_q <= zero_q;
			out_sat_q <= sat_val;
		end
	end

	assign result.valid = out_valid_q;
	assign result.similarity = out_sim_q;
	assign result.zero_norm = out_zero_q;
	assign result.saturated = out_sat_q;

endmodule

>>> rtl/core/cosine_similarity_stream.sv
// channel    | dir | payload                                 | notes
// elems      | in  | x_elem, y_elem (signed), last           | one pair per cycle when ready
// result     | out | similarity (signed Q1.15), zero_norm,   | one item per vector
//            |     | saturated                               |
// element pairs are taken one per cycle while elems is ready; a vector's sums are pushed from the product registers
// the back end works on one vector at a time (24 root steps, a multiply, 17 divide steps, overhead)
// a zero norm or an overflowing quotient skips the divide
// up to two finished vectors wait in the queue; elems stalls only when it is full
// result is held in an output register until taken
// arst_n clears the running sums, the queue and both handshakes
`include "cosine_similarity_stream_defines.svh"

module cosine_similarity_stream import csim_pkg::*; #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	csim_in_if.sink     elems,
	csim_out_if.source  result
);

	logic push, pop, q_empty, q_full;
	sums_t push_data, pop_data;

	csim_front #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.elems(elems),
		.push(push),
		.push_data(push_data),
		.q_full(q_full)
	);

	csim_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(pop_data),
		.empty(q_empty),
		.full(q_full)
	);

	csim_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_data(pop_data),
		.q_empty(q_empty),
		.pop(pop),
		.result(result)
	);

	`CSIM_ASSERT_NOW(a_push_not_full, push, !q_full, "sums pushed into a full queue")
	`CSIM_ASSERT_NOW(a_stall_only_full, !elems.ready, q_full, "input stalled with queue space")
	`CSIM_ASSERT_NOW(a_zero_norm_result, result.valid && result.zero_norm,
		result.similarity == '0 && !result.saturated, "zero norm result not cleared")
	`CSIM_ASSERT_NEXT(a_pop_leaves_idle, pop, !pop, "queue popped on consecutive cycles")

endmodule
